@@ rtl/core/sti_pkg.sv @@
// Shared types and constants of the stretch template interpolator.
package sti_pkg;

  localparam int MAX_EPOCHS_DEF  = 256;
  localparam int MAX_FILTERS_DEF = 8;

  // Shared divider widths: magnitude of numerator and divisor
  localparam int DIV_NW = 33;
  localparam int DIV_DW = 17;
  // Stretched time, signed Q10.6 at full width
  localparam int TS_W   = 31;

  localparam int STRETCH_ONE = 16384;   // 1.0 in Q2.14
  localparam int OFF_COEF    = -78;     // -0.78 scaled with OFF_DEN
  localparam int OFF_DEN     = 6400;    // Q2.14 to Q8.8 with the 1/100 of the coefficient

  typedef enum logic [2:0] {
    CFG_RISE_STRETCH    = 3'd0,
    CFG_FALL_STRETCH    = 3'd1,
    CFG_FILTER_COLUMN   = 3'd2,
    CFG_EPOCH_COUNT     = 3'd3,
    CFG_MAGNITUDE_ERROR = 3'd4
  } cfg_index_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [7:0]         epoch_slot;
    logic [2:0]         filter_slot;
    logic signed [15:0] load_time;
    logic signed [15:0] load_magnitude;
    logic signed [15:0] query_time;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] magnitude;
    logic [15:0]        error_out;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [15:0] rise_stretch;
    logic [15:0] fall_stretch;
    logic [15:0] magnitude_error;
  } cfg_t;

endpackage

@@ rtl/core/sti_stream_if.sv @@
// Valid/ready channel carrying one payload item.
interface sti_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/stretch_template_interpolator.sv @@
// Top level of the stretch template interpolator.
// Channels: in_ch takes load and evaluate items, out_ch returns one result
// per evaluate item, cfg_ch writes the five configuration registers by index
// and is always ready. All use valid/ready; an item moves when both are high.
// Load items write one time and one magnitude into the template RAMs and
// update the time span; they give no result.
// Evaluate items divide the time by the stretch on the shared serial
// divider; inside the time span they search the epoch table one entry per
// cycle and interpolate between the bracketing epochs (one more divider
// pass), outside it they take the first or last epoch's magnitude; all then
// add the luminosity offset.
// Items are worked one at a time by the back end; a two-entry queue lets the
// front take items while the back end is busy.
// A finished result sits in the output register; while the receiver stalls,
// the back end holds in its last step and the queue fills, then in_ch drops
// ready. Reset clears control, the span and the configuration; the template
// RAMs keep whatever they held and must be loaded before use.
module stretch_template_interpolator #(
  parameter int MAX_EPOCHS  = sti_pkg::MAX_EPOCHS_DEF,
  parameter int MAX_FILTERS = sti_pkg::MAX_FILTERS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sti_stream_if.sink   in_ch,
  sti_stream_if.source out_ch,
  sti_stream_if.sink   cfg_ch
);

  localparam int EW = $clog2(MAX_EPOCHS);
  localparam int FW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

  logic              push, q_ready, pop, head_valid;
  sti_pkg::in_item_t push_item, head_item;
  sti_pkg::cfg_t     cfg;
  logic [EW-1:0]     top_epoch;
  logic [FW-1:0]     col;

  sti_front #(.MAX_EPOCHS(MAX_EPOCHS), .MAX_FILTERS(MAX_FILTERS)) u_front (
    .clk, .rst_n, .in_ch, .cfg_ch, .q_ready, .push, .push_item, .cfg, .top_epoch, .col
  );

  sti_queue u_queue (
    .clk, .rst_n, .push, .push_item, .push_ready(q_ready), .pop, .head_valid, .head_item
  );

  sti_back #(.MAX_EPOCHS(MAX_EPOCHS), .MAX_FILTERS(MAX_FILTERS)) u_back (
    .clk, .rst_n, .head_valid, .head_item, .pop, .cfg, .top_epoch, .col, .out_ch
  );

endmodule

@@ rtl/core/sti_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/sti_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module sti_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sti_pkg::DIV_NW-1:0] num,
  input  logic [sti_pkg::DIV_DW-1:0] den,
  output logic                      done,
  output logic [sti_pkg::DIV_NW-1:0] quot,
  output logic                      rem_nz
);

  localparam int NW = sti_pkg::DIV_NW;
  localparam int DW = sti_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    shifted = {rem_r, num_r[NW-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign done   = done_r;
  assign quot   = num_r;
  assign rem_nz = |rem_r;

endmodule

@@ rtl/core/sti_front.sv @@
// Front end: configuration registers, item intake and load range check.
module sti_front #(
  parameter int MAX_EPOCHS  = sti_pkg::MAX_EPOCHS_DEF,
  parameter int MAX_FILTERS = sti_pkg::MAX_FILTERS_DEF,
  localparam int EW = $clog2(MAX_EPOCHS),
  localparam int FW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  sti_stream_if.sink        in_ch,
  sti_stream_if.sink        cfg_ch,
  input  logic              q_ready,
  output logic              push,
  output sti_pkg::in_item_t push_item,
  output sti_pkg::cfg_t     cfg,
  output logic [EW-1:0]     top_epoch,
  output logic [FW-1:0]     col
);

  logic [15:0] rise_r;
  logic [15:0] fall_r;
  logic [2:0]  col_r;
  logic [8:0]  count_r;
  logic [15:0] err_r;
  logic        item_ok;
  int          count_int;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r  <= 16'(sti_pkg::STRETCH_ONE);
      fall_r  <= 16'(sti_pkg::STRETCH_ONE);
      col_r   <= '0;
      count_r <= 9'd1;
      err_r   <= 16'd26;
    end else if (cfg_ch.valid) begin
      unique case (sti_pkg::cfg_index_t'(cfg_ch.data.index))
        sti_pkg::CFG_RISE_STRETCH:    rise_r  <= cfg_ch.data.data;
        sti_pkg::CFG_FALL_STRETCH:    fall_r  <= cfg_ch.data.data;
        sti_pkg::CFG_FILTER_COLUMN:   col_r   <= cfg_ch.data.data[2:0];
        sti_pkg::CFG_EPOCH_COUNT:     count_r <= cfg_ch.data.data[8:0];
        sti_pkg::CFG_MAGNITUDE_ERROR: err_r   <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  // Clamp count and column into the table
  always_comb begin
    count_int = int'(count_r);
    if (count_int == 0) count_int = 1;
    if (count_int > MAX_EPOCHS) count_int = MAX_EPOCHS;
    top_epoch = EW'(count_int - 1);
    col = (int'(col_r) >= MAX_FILTERS) ? FW'(MAX_FILTERS - 1) : FW'(col_r);
  end

  assign cfg = '{rise_stretch: rise_r, fall_stretch: fall_r, magnitude_error: err_r};

  // Drop loads aimed outside the table
  assign item_ok = (in_ch.data.mode == sti_pkg::MODE_EVAL) ||
                   ((int'(in_ch.data.epoch_slot) < MAX_EPOCHS) &&
                    (int'(in_ch.data.filter_slot) < MAX_FILTERS));
  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready && item_ok;
  assign push_item   = in_ch.data;

endmodule

@@ rtl/core/sti_queue.sv @@
// Two-entry item queue between front and back end.
module sti_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sti_pkg::in_item_t push_item,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output sti_pkg::in_item_t head_item
);

  sti_pkg::in_item_t slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        fill_r;

  assign push_ready = fill_r != 2'd2;
  assign head_valid = fill_r != 2'd0;
  assign head_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ rtl/core/sti_back.sv @@
// Back end: table writes, stretch divide, bracket search, interpolation, offset.
module sti_back #(
  parameter int MAX_EPOCHS  = sti_pkg::MAX_EPOCHS_DEF,
  parameter int MAX_FILTERS = sti_pkg::MAX_FILTERS_DEF,
  localparam int EW  = $clog2(MAX_EPOCHS),
  localparam int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1,
  localparam int MD  = MAX_EPOCHS * MAX_FILTERS,
  localparam int MAW = $clog2(MD)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  sti_pkg::in_item_t head_item,
  output logic              pop,
  input  sti_pkg::cfg_t     cfg,
  input  logic [EW-1:0]     top_epoch,
  input  logic [FW-1:0]     col,
  sti_stream_if.source      out_ch
);

  localparam int NW = sti_pkg::DIV_NW;
  localparam int DW = sti_pkg::DIV_DW;
  localparam int TW = sti_pkg::TS_W;
  // Offset divide by 2*OFF_DEN = 512 * 25: shift by 9, then reciprocal of 25
  localparam int OFF_BIAS  = 600;
  localparam int OFF_RECIP = 20972;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_T, S_CLASS, S_SEARCH, S_RD1, S_RD1_W, S_RDA, S_RDB, S_RDB_W,
    S_MUL, S_NUM, S_DIV_M, S_OFF, S_OFF_Q, S_DONE
  } state_t;

  state_t                 state_r;
  sti_pkg::in_item_t      cmd_r;
  logic signed [15:0]     min_r, max_r;
  logic signed [TW-1:0]   tstr_r;
  logic [EW:0]            ja_r;
  logic [EW-1:0]          jd_r, j_r, sel_r;
  logic                   pend_r;
  logic signed [15:0]     prev_t_r, t2_r;
  logic [16:0]            w1_r, w2_r;
  logic signed [15:0]     m1_r, m2_r, mag_r, off_r;
  logic signed [33:0]     p1_r, p2_r;
  logic                   div_neg_r, div_floor_r;
  logic                   out_valid_r;
  sti_pkg::out_item_t     out_data_r;
  logic [14:0]            off_y_r;

  // RAM and divider hookup
  logic                   t_we, m_we;
  logic [EW-1:0]          t_waddr, t_raddr;
  logic [MAW-1:0]         m_waddr, m_raddr;
  logic [15:0]            t_rdata, m_rdata;
  logic                   div_start, div_done, div_rem_nz;
  logic [NW-1:0]          div_num, div_quot, q_adj;
  logic [DW-1:0]          div_den;
  logic                   div_neg;
  logic signed [NW:0]     div_res;
  logic                   is_load, is_eval;
  logic [NW-1:0]          tq_num;
  logic [15:0]            stretch;
  logic signed [TW-1:0]   tstr_calc;
  logic                   issue;
  logic signed [34:0]     n_sum;
  logic signed [36:0]     n_big;
  logic [17:0]            d_sum;
  int                     off_n;
  logic [14:0]            off_y;
  logic [29:0]            off_prod;
  logic signed [16:0]     sum;
  logic signed [31:0]     w1_calc, w2_calc;

  sti_ram #(.WIDTH(16), .DEPTH(MAX_EPOCHS)) u_times (
    .clk, .wr_en(t_we), .wr_addr(t_waddr), .wr_data(head_item.load_time),
    .rd_addr(t_raddr), .rd_data(t_rdata)
  );

  sti_ram #(.WIDTH(16), .DEPTH(MD)) u_mags (
    .clk, .wr_en(m_we), .wr_addr(m_waddr), .wr_data(head_item.load_magnitude),
    .rd_addr(m_raddr), .rd_data(m_rdata)
  );

  sti_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot), .rem_nz(div_rem_nz)
  );

  assign pop     = (state_r == S_IDLE) && head_valid;
  assign is_load = pop && (head_item.mode == sti_pkg::MODE_LOAD);
  assign is_eval = pop && (head_item.mode == sti_pkg::MODE_EVAL);

  assign t_we    = is_load;
  assign m_we    = is_load;
  assign t_waddr = EW'(head_item.epoch_slot);
  assign m_waddr = MAW'(int'(head_item.epoch_slot) * MAX_FILTERS + int'(head_item.filter_slot));

  assign issue   = ja_r <= {1'b0, top_epoch};
  assign t_raddr = ja_r[EW-1:0];

  always_comb begin
    unique case (state_r)
      S_RDA:   m_raddr = MAW'(int'(j_r - 1'b1) * MAX_FILTERS + int'(col));
      S_RDB:   m_raddr = MAW'(int'(j_r) * MAX_FILTERS + int'(col));
      default: m_raddr = MAW'(int'(sel_r) * MAX_FILTERS + int'(col));
    endcase
  end

  // Stretch divide operands
  always_comb begin
    stretch = head_item.query_time[15] ? cfg.rise_stretch : cfg.fall_stretch;
    if (stretch == 16'd0) stretch = 16'd1;
    tq_num = NW'(head_item.query_time[15] ? -int'(head_item.query_time)
                                          : int'(head_item.query_time)) << 14;
  end

  // Interpolation numerator: 2*(w1*m1 + w2*m2) + (w1 + w2)
  always_comb begin
    n_sum = 35'(p1_r) + 35'(p2_r);
    d_sum = {1'b0, w1_r} + {1'b0, w2_r};
    n_big = (37'(n_sum) <<< 1) + 37'($signed({1'b0, d_sum}));
  end

  // Offset: bias keeps the rounding numerator positive for the reciprocal divide
  always_comb begin
    off_n = 2 * sti_pkg::OFF_COEF * (int'(cfg.fall_stretch) - sti_pkg::STRETCH_ONE)
            + sti_pkg::OFF_DEN;
    off_y = 15'((off_n + OFF_BIAS * 2 * sti_pkg::OFF_DEN) >>> 9);
    off_prod = 30'(off_y_r) * 30'(OFF_RECIP);
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = tq_num;
    div_den   = DW'(stretch);
    div_neg   = head_item.query_time[15];
    unique case (state_r)
      S_IDLE: div_start = is_eval;
      S_NUM: begin
        div_start = 1'b1;
        div_neg   = n_big < 0;
        div_num   = NW'(n_big < 0 ? -n_big : n_big);
        div_den   = DW'({d_sum, 1'b0});
      end
      default: ;
    endcase
  end

  // Signed result: truncation for the stretch, floor for the rounding divide
  always_comb begin
    q_adj   = (div_floor_r && div_neg_r && div_rem_nz) ? div_quot + 1'b1 : div_quot;
    div_res = div_neg_r ? -$signed({1'b0, q_adj}) : $signed({1'b0, q_adj});
    tstr_calc = TW'(div_res);
    w1_calc = 32'(t2_r) - 32'(tstr_r);
    w2_calc = 32'(tstr_r) - 32'(prev_t_r);
    sum     = 17'(mag_r) + 17'(off_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= 16'sh7FFF;
      max_r       <= -16'sh8000;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (is_load) begin
            if (head_item.load_time < min_r) min_r <= head_item.load_time;
            if (head_item.load_time > max_r) max_r <= head_item.load_time;
          end
          if (is_eval) begin
            cmd_r       <= head_item;
            div_neg_r   <= div_neg;
            div_floor_r <= 1'b0;
            state_r     <= S_DIV_T;
          end
        end
        S_DIV_T: if (div_done) begin
          tstr_r  <= tstr_calc;
          state_r <= S_CLASS;
        end
        S_CLASS: begin
          if (tstr_r < TW'(min_r)) begin
            sel_r   <= '0;
            state_r <= S_RD1;
          end else if (tstr_r >= TW'(max_r)) begin
            sel_r   <= top_epoch;
            state_r <= S_RD1;
          end else begin
            ja_r    <= '0;
            pend_r  <= 1'b0;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          ja_r   <= ja_r + (EW+1)'(issue);
          pend_r <= issue;
          jd_r   <= ja_r[EW-1:0];
          if (pend_r) begin
            // First epoch later than the stretched time is the upper bracket
            if (TW'($signed(t_rdata)) > tstr_r) begin
              pend_r <= 1'b0;
              if (jd_r == '0) begin
                sel_r   <= '0;
                state_r <= S_RD1;
              end else begin
                j_r     <= jd_r;
                t2_r    <= t_rdata;
                state_r <= S_RDA;
              end
            end else begin
              prev_t_r <= t_rdata;
              if (jd_r == top_epoch) begin
                pend_r  <= 1'b0;
                sel_r   <= top_epoch;
                state_r <= S_RD1;
              end
            end
          end
        end
        S_RD1:   state_r <= S_RD1_W;
        S_RD1_W: begin
          mag_r   <= m_rdata;
          state_r <= S_OFF;
        end
        S_RDA: begin
          w1_r    <= 17'(w1_calc);
          w2_r    <= 17'(w2_calc);
          state_r <= S_RDB;
        end
        S_RDB: begin
          m1_r    <= m_rdata;
          state_r <= S_RDB_W;
        end
        S_RDB_W: begin
          m2_r    <= m_rdata;
          state_r <= S_MUL;
        end
        S_MUL: begin
          p1_r    <= $signed({1'b0, w1_r}) * m1_r;
          p2_r    <= $signed({1'b0, w2_r}) * m2_r;
          state_r <= S_NUM;
        end
        S_NUM: begin
          div_neg_r   <= div_neg;
          div_floor_r <= 1'b1;
          state_r     <= S_DIV_M;
        end
        S_DIV_M: if (div_done) begin
          mag_r   <= div_res[15:0];
          state_r <= S_OFF;
        end
        S_OFF: begin
          off_y_r <= off_y;
          state_r <= S_OFF_Q;
        end
        S_OFF_Q: begin
          off_r   <= 16'(int'(off_prod[29:19]) - OFF_BIAS);
          state_r <= S_DONE;
        end
        S_DONE: if (!out_valid_r || out_ch.ready) begin
          out_data_r.magnitude <= (sum > 17'sd32767) ? 16'sh7FFF :
                                  (sum < -17'sd32768) ? -16'sh8000 : sum[15:0];
          out_data_r.error_out <= cfg.magnitude_error;
          out_data_r.last_out  <= cmd_r.last_point;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule
